>>> rtl/adcdt_pkg.sv
// ----------------------------------------------------------------------------
// adcdt_pkg: shared constants for the ADC reading to decimal text block
// Scaling factors, reciprocal multipliers for the constant divisions and the
// ASCII codes used to build the text of one reading.
// ----------------------------------------------------------------------------
package adcdt_pkg;

	localparam int ADC_W   = 10;
	localparam int CHAR_W  = 7;
	localparam int MAX_LEN = 6;

	// Scaling of the raw sample to thousandths: t = (adc * 4921) >> 10.
	localparam logic [12:0] SCALE_NUM   = 13'd4921;
	localparam int          SCALE_SHIFT = 10;

	// Voltage channel: 5*t + 17640, "Off" below 18100.
	localparam logic [15:0] VOLT_OFFSET    = 16'd17640;
	localparam logic [15:0] VOLT_THRESHOLD = 16'd18100;
	localparam logic [15:0] ROUND_BIAS     = 16'd5;

	// Reciprocal constants. Each is exact over the value range it sees here.
	localparam logic [15:0] RECIP10_16  = 16'd52429; // x/10  = (x*52429) >> 19
	localparam int          RECIP10_SH  = 19;
	localparam logic [12:0] RECIP100    = 13'd5243;  // h/100 = (h*5243) >> 19
	localparam int          RECIP100_SH = 19;
	localparam logic [7:0]  RECIP10_8   = 8'd205;    // y/10  = (y*205) >> 11
	localparam int          RECIP10_8SH = 11;

	typedef logic [CHAR_W-1:0] char_t;

	localparam char_t CH_ZERO    = 7'd48;
	localparam char_t CH_POINT   = 7'd46;
	localparam char_t CH_SPACE   = 7'd32;
	localparam char_t CH_NEWLINE = 7'd10;
	localparam char_t CH_UPPER_O = 7'd79;
	localparam char_t CH_LOWER_F = 7'd102;

	localparam logic FUNC_VOLT = 1'b0;
	localparam logic FUNC_CURR = 1'b1;

endpackage

>>> rtl/adc_reading_to_decimal_text.sv
// ----------------------------------------------------------------------------
// adc_reading_to_decimal_text: formats one ADC sample as ASCII decimal text
// Six-stage arithmetic pipeline followed by a character serializer.
// ----------------------------------------------------------------------------
// Usage:
// An item (adc_sample, func) is taken at a rising edge where start is high and
// busy is low. Each item becomes 4, 5 or 6 characters on text_char, one per
// cycle, each marked by strobe for exactly one cycle; last_char flags the
// final character of the item. The receiver cannot stall, so every strobed
// character must be taken in the cycle it is shown.
// The first character of an item is shown once the item has passed stages 1
// to 6 and been loaded into the serializer. The arithmetic pipeline can take
// an item every cycle while busy is low; the sustained rate is limited by the
// single character output port.
// When the serializer is still busy with an earlier item, the pipeline stages
// fill and busy rises; items held in the stages are neither lost nor repeated.
// Characters of an item waiting in stage 6 follow the previous item with no gap.
// Reset (arst_n low) clears all valid bits and the serializer count, so no
// strobe appears until a new item has gone through the pipeline.
// ----------------------------------------------------------------------------
module adc_reading_to_decimal_text (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [adcdt_pkg::ADC_W-1:0]   adc_sample,
	input  logic                          func,
	output logic                          strobe,
	output logic [adcdt_pkg::CHAR_W-1:0]  text_char,
	output logic                          last_char
);

	// Stage valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// Stage 1: scaled reading in thousandths (0..4916).
	logic [12:0] t_s1;
	logic        func_s1;

	// Stage 2: rounding input (value + 5) and the "Off" decision.
	logic [15:0] x_s2;
	logic        off_s2, func_s2;

	// Stage 3: value in hundredths, h = x / 10.
	logic [12:0] h_s3;
	logic        off_s3, func_s3;

	// Stage 4: integer part, ip = h / 100.
	logic [12:0] h_s4;
	logic [5:0]  ip_s4;
	logic        off_s4, func_s4;

	// Stage 5: fraction part and the tens digit of the integer part.
	logic [6:0]  fp_s5;
	logic [5:0]  ip_s5;
	logic [2:0]  tens_i_s5;
	logic        off_s5, func_s5;

	// Stage 6: integer digits and the first fraction digit.
	logic [6:0]  fp_s6;
	logic [2:0]  tens_i_s6;
	logic [3:0]  ones_i_s6;
	logic [3:0]  tens_f_s6;
	logic        off_s6, func_s6;

	// Serializer: characters waiting to leave, lowest slot goes out first.
	adcdt_pkg::char_t chars_q [adcdt_pkg::MAX_LEN];
	logic [2:0]       left_q;

	// Stage load enables; a stage loads when it is empty or its content moves on.
	logic mv1, mv2, mv3, mv4, mv5, mv6;

	always_comb begin
		mv6 = (left_q <= 3'd1);
		mv5 = !v_s6 || mv6;
		mv4 = !v_s5 || mv5;
		mv3 = !v_s4 || mv4;
		mv2 = !v_s3 || mv3;
		mv1 = !v_s2 || mv2;
	end

	logic take1;
	assign take1 = !v_s1 || mv1;
	assign busy  = !take1;

	// Arithmetic for each stage.
	logic [22:0] prod_t;
	logic [15:0] v_c;
	logic [31:0] prod_h;
	logic [25:0] prod_ip;
	logic [12:0] fp_wide;
	logic [13:0] prod_ti;
	logic [3:0]  ones_i_c;
	logic [14:0] prod_tf;
	logic [3:0]  ones_f_c;

	always_comb begin
		prod_t   = 23'(adc_sample) * 23'(adcdt_pkg::SCALE_NUM);
		v_c      = (func_s1 == adcdt_pkg::FUNC_CURR) ? 16'(t_s1)
		         : 16'({t_s1, 2'b00}) + 16'(t_s1) + adcdt_pkg::VOLT_OFFSET;
		prod_h   = 32'(x_s2) * 32'(adcdt_pkg::RECIP10_16);
		prod_ip  = 26'(h_s3) * 26'(adcdt_pkg::RECIP100);
		fp_wide  = h_s4 - 13'(13'(ip_s4) * 13'd100);
		prod_ti  = 14'(ip_s4) * 14'(adcdt_pkg::RECIP10_8);
		ones_i_c = 4'(ip_s5 - 6'(6'(tens_i_s5) * 6'd10));
		prod_tf  = 15'(fp_s5) * 15'(adcdt_pkg::RECIP10_8);
		ones_f_c = 4'(fp_s6 - 7'(7'(tens_f_s6) * 7'd10));
	end

	// Text of the item in stage 6, packed from slot 0.
	adcdt_pkg::char_t txt [adcdt_pkg::MAX_LEN];
	logic [2:0]       txt_len;
	adcdt_pkg::char_t term_c;

	always_comb begin
		term_c = (func_s6 == adcdt_pkg::FUNC_CURR) ? adcdt_pkg::CH_NEWLINE
		                                          : adcdt_pkg::CH_SPACE;
		for (int i = 0; i < adcdt_pkg::MAX_LEN; i++) begin
			txt[i] = adcdt_pkg::CH_SPACE;
		end
		if (off_s6) begin
			txt[0]  = adcdt_pkg::CH_UPPER_O;
			txt[1]  = adcdt_pkg::CH_LOWER_F;
			txt[2]  = adcdt_pkg::CH_LOWER_F;
			txt[3]  = adcdt_pkg::CH_SPACE;
			txt_len = 3'd4;
		end else if (tens_i_s6 != 3'd0) begin
			txt[0]  = adcdt_pkg::CH_ZERO + 7'(tens_i_s6);
			txt[1]  = adcdt_pkg::CH_ZERO + 7'(ones_i_s6);
			txt[2]  = adcdt_pkg::CH_POINT;
			txt[3]  = adcdt_pkg::CH_ZERO + 7'(tens_f_s6);
			txt[4]  = adcdt_pkg::CH_ZERO + 7'(ones_f_c);
			txt[5]  = term_c;
			txt_len = 3'd6;
		end else begin
			txt[0]  = adcdt_pkg::CH_ZERO + 7'(ones_i_s6);
			txt[1]  = adcdt_pkg::CH_POINT;
			txt[2]  = adcdt_pkg::CH_ZERO + 7'(tens_f_s6);
			txt[3]  = adcdt_pkg::CH_ZERO + 7'(ones_f_c);
			txt[4]  = term_c;
			txt_len = 3'd5;
		end
	end

	// Valid bits and serializer count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			left_q <= 3'd0;
		end else begin
			if (take1) v_s1 <= start;
			if (mv1)   v_s2 <= v_s1;
			if (mv2)   v_s3 <= v_s2;
			if (mv3)   v_s4 <= v_s3;
			if (mv4)   v_s5 <= v_s4;
			if (mv5)   v_s6 <= v_s5;
			if (mv6 && v_s6) begin
				left_q <= txt_len;
			end else if (left_q != 3'd0) begin
				left_q <= left_q - 3'd1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take1) begin
			t_s1    <= prod_t[adcdt_pkg::SCALE_SHIFT +: 13];
			func_s1 <= func;
		end
		if (mv1) begin
			x_s2    <= v_c + adcdt_pkg::ROUND_BIAS;
			off_s2  <= (func_s1 == adcdt_pkg::FUNC_VOLT)
			        && (v_c < adcdt_pkg::VOLT_THRESHOLD);
			func_s2 <= func_s1;
		end
		if (mv2) begin
			h_s3    <= prod_h[adcdt_pkg::RECIP10_SH +: 13];
			off_s3  <= off_s2;
			func_s3 <= func_s2;
		end
		if (mv3) begin
			h_s4    <= h_s3;
			ip_s4   <= prod_ip[adcdt_pkg::RECIP100_SH +: 6];
			off_s4  <= off_s3;
			func_s4 <= func_s3;
		end
		if (mv4) begin
			fp_s5     <= fp_wide[6:0];
			ip_s5     <= ip_s4;
			tens_i_s5 <= prod_ti[adcdt_pkg::RECIP10_8SH +: 3];
			off_s5    <= off_s4;
			func_s5   <= func_s4;
		end
		if (mv5) begin
			fp_s6     <= fp_s5;
			tens_i_s6 <= tens_i_s5;
			ones_i_s6 <= ones_i_c;
			tens_f_s6 <= prod_tf[adcdt_pkg::RECIP10_8SH +: 4];
			off_s6    <= off_s5;
			func_s6   <= func_s5;
		end
		if (mv6 && v_s6) begin
			chars_q <= txt;
		end else begin
			for (int i = 0; i < adcdt_pkg::MAX_LEN - 1; i++) begin
				chars_q[i] <= chars_q[i+1];
			end
		end
	end

	assign strobe    = (left_q != 3'd0);
	assign text_char = chars_q[0];
	assign last_char = (left_q == 3'd1);

endmodule
